>>> hw/rtl/ztrs_pkg.sv
package ztrs_pkg;

  localparam int unsigned SERIAL_W   = 32;
  localparam int unsigned ACTION_W   = 4;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_AW     = 3;
  localparam int unsigned CFG_DW     = 32;
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam logic [0:0] REG_INCR_REQ = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SOA       = 4'd0,
    ACT_ADD       = 4'd1,
    ACT_DEL       = 4'd2,
    ACT_CLEAR_ADD = 4'd3,
    ACT_FINAL     = 4'd4,
    ERR_OUTSIDE   = 4'd5,
    ERR_NOT_SOA   = 4'd6,
    ERR_OWNER1    = 4'd7,
    ERR_OWNER     = 4'd8,
    ERR_AXFR_LOW  = 4'd9,
    ERR_ORDER     = 4'd10,
    ERR_HIGH      = 4'd11
  } action_t;

  typedef enum logic [1:0] {
    KIND_RECORD      = 2'd0,
    KIND_SOA_ZONE    = 2'd1,
    KIND_SOA_FOREIGN = 2'd2
  } kind_t;

  typedef enum logic [5:0] {
    ST_NEED_FIRST = 6'b000001,
    ST_HAVE_FIRST = 6'b000010,
    ST_DEL        = 6'b000100,
    ST_ADD        = 6'b001000,
    ST_FINAL      = 6'b010000,
    ST_HALT       = 6'b100000
  } stage_t;

  typedef struct packed {
    logic                first;
    kind_t               kind;
    logic [SERIAL_W-1:0] serial;
  } req_t;

  typedef struct packed {
    logic               valid;
    logic               full;
    logic [Q_CNT_W-1:0] level;
  } q_status_t;

endpackage

>>> hw/rtl/ztrs_front.sv
module ztrs_front (
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ztrs_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  ztrs_pkg::q_status_t                q_status,
  output logic                               q_push,
  output ztrs_pkg::req_t                     q_req
);
  import ztrs_pkg::*;

  logic is_soa;
  logic owner_ok;

  assign is_soa   = in_tdata[1];
  assign owner_ok = in_tdata[2];

  assign in_tready = !q_status.full;
  assign q_push    = in_tvalid && !q_status.full;

  always_comb begin
    q_req.first  = in_tdata[0];
    q_req.serial = in_tdata[3 +: SERIAL_W];
    if (!is_soa) begin
      q_req.kind = KIND_RECORD;
    end else if (owner_ok) begin
      q_req.kind = KIND_SOA_ZONE;
    end else begin
      q_req.kind = KIND_SOA_FOREIGN;
    end
  end

endmodule

>>> hw/rtl/ztrs_queue.sv
module ztrs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ztrs_pkg::req_t      push_req,
  input  logic                pop,
  output ztrs_pkg::req_t      head_req,
  output ztrs_pkg::q_status_t status
);
  import ztrs_pkg::*;

  req_t                entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr_r;
  logic [Q_PTR_W-1:0]  wr_ptr_nxt;
  logic [Q_PTR_W-1:0]  rd_ptr_r;
  logic [Q_PTR_W-1:0]  rd_ptr_nxt;
  logic [Q_CNT_W-1:0]  count_r;
  logic [Q_CNT_W-1:0]  count_nxt;

  assign head_req     = entry_r[rd_ptr_r];
  assign status.valid = (count_r != '0);
  assign status.full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign status.level = count_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/ztrs_back.sv
module ztrs_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             incr_req,
  input  logic                             q_valid,
  input  ztrs_pkg::req_t                   head_req,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ztrs_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ztrs_pkg::*;

  stage_t              stage_r;
  stage_t              stage_nxt;
  logic                mode_r;
  logic                mode_nxt;
  logic [SERIAL_W-1:0] first_serial_r;
  logic [SERIAL_W-1:0] first_serial_nxt;
  logic [SERIAL_W-1:0] last_soa_serial_r;
  logic [SERIAL_W-1:0] last_soa_serial_nxt;
  logic                out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  stage_t              st;
  logic                md;
  logic [SERIAL_W-1:0] fs;
  logic [SERIAL_W-1:0] ps;
  action_t             act;
  logic                ser_eq;
  logic                ser_lt;
  logic                ser_le_prev;

  assign q_pop      = q_valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    st = stage_r;
    md = mode_r;
    fs = first_serial_r;
    ps = last_soa_serial_r;
    if (head_req.first) begin
      st = ST_NEED_FIRST;
      md = incr_req;
      fs = '0;
      ps = '0;
    end

    ser_eq      = (head_req.serial == fs);
    ser_lt      = (head_req.serial < fs);
    ser_le_prev = (head_req.serial <= ps);

    act                 = ACT_SOA;
    stage_nxt           = st;
    mode_nxt            = md;
    first_serial_nxt    = fs;
    last_soa_serial_nxt = ps;

    unique case (st)
      ST_FINAL: begin
        act       = ERR_OUTSIDE;
        stage_nxt = ST_HALT;
      end
      ST_NEED_FIRST: begin
        if (head_req.kind == KIND_RECORD) begin
          act       = ERR_NOT_SOA;
          stage_nxt = ST_HALT;
        end else begin
          first_serial_nxt = head_req.serial;
          if (head_req.kind == KIND_SOA_FOREIGN) begin
            act       = ERR_OWNER1;
            stage_nxt = ST_HALT;
          end else begin
            stage_nxt = ST_HAVE_FIRST;
          end
        end
      end
      ST_HAVE_FIRST, ST_DEL, ST_ADD: begin
        priority if (head_req.kind == KIND_SOA_FOREIGN) begin
          act       = ERR_OWNER;
          stage_nxt = ST_HALT;
        end else if (head_req.kind == KIND_SOA_ZONE) begin
          priority if (ser_eq) begin
            last_soa_serial_nxt = head_req.serial;
            if (md && st == ST_DEL) begin
              stage_nxt = ST_ADD;
            end else begin
              act       = ACT_FINAL;
              stage_nxt = ST_FINAL;
            end
          end else if (ser_lt) begin
            priority if (!md) begin
              act       = ERR_AXFR_LOW;
              stage_nxt = ST_HALT;
            end else if (st != ST_DEL) begin
              stage_nxt           = ST_DEL;
              last_soa_serial_nxt = head_req.serial;
            end else if (ser_le_prev) begin
              act       = ERR_ORDER;
              stage_nxt = ST_HALT;
            end else begin
              stage_nxt           = ST_ADD;
              last_soa_serial_nxt = head_req.serial;
            end
          end else begin
            act       = ERR_HIGH;
            stage_nxt = ST_HALT;
          end
        end else begin
          priority if (st == ST_ADD) begin
            act = ACT_ADD;
          end else if (st == ST_DEL) begin
            act = ACT_DEL;
          end else begin
            stage_nxt = ST_ADD;
            if (md) begin
              mode_nxt = 1'b0;
              act      = ACT_CLEAR_ADD;
            end else begin
              act = ACT_ADD;
            end
          end
        end
      end
      default: begin
        act = ERR_OUTSIDE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= {3'b000, first_serial_nxt, mode_nxt, act};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r           <= ST_NEED_FIRST;
      mode_r            <= 1'b0;
      first_serial_r    <= '0;
      last_soa_serial_r <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (q_pop) begin
        stage_r           <= stage_nxt;
        mode_r            <= mode_nxt;
        first_serial_r    <= first_serial_nxt;
        last_soa_serial_r <= last_soa_serial_nxt;
        out_valid_r       <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/zone_transfer_record_sequencer.sv
// Takes one zone transfer answer record per cycle while the output is ready, and returns one
// result per record, in order. A record waits in a four-entry queue between the input
// classifier and the transfer sequencer, whose serial compares are combinational, so the
// sustained rate is one record per clock while out_tready stays high; the result is held in
// a register after the queue entry. The result register and the queue absorb output stalls.
// Write incremental_requested only while no record is in flight; it takes effect on the
// next record that has first_record set.
module zone_transfer_record_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  // Fields from bit 0: first_record, record_is_soa, owner_is_zone, soa_serial[31:0].
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ztrs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Fields from bit 0: action[3:0], incremental_active, leadin_serial[31:0].
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ztrs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [ztrs_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [ztrs_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [ztrs_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import ztrs_pkg::*;

  logic      incr_req_r;
  logic      cfg_sel_reg;
  logic      q_push;
  logic      q_pop;
  req_t      q_req;
  req_t      head_req;
  q_status_t q_status;

  assign cfg_pready  = 1'b1;
  assign cfg_sel_reg = (cfg_paddr[CFG_AW-1:2] == REG_INCR_REQ);
  assign cfg_prdata  = cfg_sel_reg ? {{(CFG_DW-1){1'b0}}, incr_req_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      incr_req_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_reg) begin
      incr_req_r <= cfg_pwdata[0];
    end
  end

  ztrs_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_status  (q_status),
    .q_push    (q_push),
    .q_req     (q_req)
  );

  ztrs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (q_req),
    .pop      (q_pop),
    .head_req (head_req),
    .status   (q_status)
  );

  ztrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .incr_req   (incr_req_r),
    .q_valid    (q_status.valid),
    .head_req   (head_req),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_clear_ends_incr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[ACTION_W-1:0] == ACT_CLEAR_ADD) |-> !out_tdata[ACTION_W])
    else $error("clear-then-add result still reports incremental mode");

  a_queue_level: assert property (@(posedge clk) disable iff (!rst_n)
    q_status.level <= Q_CNT_W'(Q_DEPTH))
    else $error("request queue level above its depth");

  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[ACTION_W-1:0] <= ERR_HIGH)
    else $error("result carries an undefined action code");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (q_status.full && !q_pop) |=> q_status.full)
    else $error("full request queue lost an entry without a pop");

endmodule

>>> verif/ztrs_result_checker.sv
module ztrs_result_checker
  import ztrs_pkg::*;
#(
  parameter logic [CFG_AW-1:0] INCR_REQ_ADDR = '0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic                   cfg_pready,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output int                     failures,
  output int                     pending,
  output int                     checked,
  output int                     error_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    action_t             action;
    logic                incr;
    logic [SERIAL_W-1:0] lead;
  } zone_result_t;

  stage_t              xfer_stage;
  logic                incr_mode;
  logic                incr_request;
  logic [SERIAL_W-1:0] leadin;
  logic [SERIAL_W-1:0] last_soa;
  zone_result_t        expected_results[$];

  function automatic action_t next_action(input logic first, input logic is_soa,
                                          input logic owner_ok,
                                          input logic [SERIAL_W-1:0] serial);
    if (first) begin
      xfer_stage = ST_NEED_FIRST;
      incr_mode  = incr_request;
      leadin     = '0;
      last_soa   = '0;
    end
    case (xfer_stage)
      ST_HALT: return ERR_OUTSIDE;
      ST_FINAL: begin
        xfer_stage = ST_HALT;
        return ERR_OUTSIDE;
      end
      ST_NEED_FIRST: begin
        if (!is_soa) begin
          xfer_stage = ST_HALT;
          return ERR_NOT_SOA;
        end
        leadin = serial;
        if (!owner_ok) begin
          xfer_stage = ST_HALT;
          return ERR_OWNER1;
        end
        xfer_stage = ST_HAVE_FIRST;
        return ACT_SOA;
      end
      default: ;
    endcase
    if (!is_soa) begin
      if (xfer_stage == ST_ADD) return ACT_ADD;
      if (xfer_stage == ST_DEL) return ACT_DEL;
      // A plain record right after the lead-in SOA means the server sent a full zone.
      xfer_stage = ST_ADD;
      if (incr_mode) begin
        incr_mode = 1'b0;
        return ACT_CLEAR_ADD;
      end
      return ACT_ADD;
    end
    if (!owner_ok) begin
      xfer_stage = ST_HALT;
      return ERR_OWNER;
    end
    if (serial == leadin) begin
      last_soa = serial;
      if (incr_mode && xfer_stage == ST_DEL) begin
        xfer_stage = ST_ADD;
        return ACT_SOA;
      end
      xfer_stage = ST_FINAL;
      return ACT_FINAL;
    end
    if (serial > leadin) begin
      xfer_stage = ST_HALT;
      return ERR_HIGH;
    end
    if (!incr_mode) begin
      xfer_stage = ST_HALT;
      return ERR_AXFR_LOW;
    end
    if (xfer_stage == ST_DEL) begin
      if (serial <= last_soa) begin
        xfer_stage = ST_HALT;
        return ERR_ORDER;
      end
      xfer_stage = ST_ADD;
    end else begin
      xfer_stage = ST_DEL;
    end
    last_soa = serial;
    return ACT_SOA;
  endfunction

  always @(posedge clk) begin
    zone_result_t exp_res;
    if (!rst_n) begin
      xfer_stage    = ST_NEED_FIRST;
      incr_mode     = 1'b0;
      incr_request  = 1'b0;
      leadin        = '0;
      last_soa      = '0;
      failures      = 0;
      checked       = 0;
      error_results = 0;
      expected_results.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == INCR_REQ_ADDR) begin
        incr_request = cfg_pwdata[0];
      end
      if (in_tvalid && in_tready) begin
        exp_res.action = next_action(in_tdata[0], in_tdata[1], in_tdata[2],
                                     in_tdata[3 +: SERIAL_W]);
        exp_res.incr   = incr_mode;
        exp_res.lead   = leadin;
        expected_results = {expected_results, exp_res};
      end
      if (out_tvalid && out_tready) begin
        checked++;
        if (expected_results.size() == 0) begin
          failures++;
          $display("%0t: unexpected result, expected none, actual 0x%h", $time, out_tdata);
        end else begin
          exp_res = expected_results.pop_front();
          if (exp_res.action >= ERR_OUTSIDE) error_results++;
          if (out_tdata[ACTION_W-1:0] != exp_res.action) begin
            failures++;
            $display("%0t: action expected %0d, actual %0d", $time, exp_res.action,
                     out_tdata[ACTION_W-1:0]);
          end
          if (out_tdata[ACTION_W] != exp_res.incr) begin
            failures++;
            $display("%0t: incremental_active expected %0d, actual %0d", $time, exp_res.incr,
                     out_tdata[ACTION_W]);
          end
          if (out_tdata[ACTION_W+1 +: SERIAL_W] != exp_res.lead) begin
            failures++;
            $display("%0t: leadin_serial expected 0x%h, actual 0x%h", $time, exp_res.lead,
                     out_tdata[ACTION_W+1 +: SERIAL_W]);
          end
        end
      end
    end
    pending = expected_results.size();
  end

endmodule

>>> verif/tb_zone_transfer_record_sequencer.sv
module tb_zone_transfer_record_sequencer;
  import ztrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_AW-1:0] INCR_REQ_ADDR = {REG_INCR_REQ, 2'b00};
  localparam int RANDOM_RECORDS = 850;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_AW-1:0]      cfg_paddr;
  logic [CFG_DW-1:0]      cfg_pwdata;
  logic [CFG_DW-1:0]      cfg_prdata;
  logic                   cfg_pready;

  int   failures;
  int   pending;
  int   checked;
  int   error_results;
  int   records_sent = 0;
  int   settings_used = 0;
  int   incr_settings = 0;
  int   target;
  int   phase_end;
  int   pick;
  logic quiet_phase = 1'b0;

  zone_transfer_record_sequencer DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  ztrs_result_checker #(
    .INCR_REQ_ADDR (INCR_REQ_ADDR)
  ) result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .failures      (failures),
    .pending       (pending),
    .checked       (checked),
    .error_results (error_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_tready <= quiet_phase || ($urandom_range(99) >= 31);
  end

  task automatic send_item(input logic first, input logic is_soa, input logic owner,
                           input logic [SERIAL_W-1:0] serial, input bit may_break);
    if (may_break && $urandom_range(99) < 4) begin
      case ($urandom_range(2))
        0: is_soa = ~is_soa;
        1: owner = ~owner;
        default: serial = serial ^ (32'h1 << $urandom_range(31));
      endcase
    end
    while (!quiet_phase && $urandom_range(99) < 31) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-3-SERIAL_W){1'b0}}, serial, owner, is_soa, first};
    do @(posedge clk); while (!in_tready);
    records_sent++;
  endtask

  task automatic send_noise();
    send_item($urandom_range(3) == 0, 1'($urandom_range(1)), 1'($urandom_range(1)),
              $urandom, 1'b0);
  endtask

  task automatic send_axfr(input int n);
    logic [SERIAL_W-1:0] lead;
    lead = $urandom;
    send_item(1'b1, 1'b1, 1'b1, lead, 1'b1);
    repeat (n) send_item(1'b0, 1'b0, 1'($urandom_range(1)), $urandom, 1'b1);
    send_item(1'b0, 1'b1, 1'b1, lead, 1'b1);
  endtask

  // Serials climb by one step per difference sequence and end at the lead-in serial.
  task automatic send_ixfr(input int diffs);
    logic [SERIAL_W-1:0] lead;
    logic [SERIAL_W-1:0] step;
    step = $urandom_range(32'h0010_0000, 1);
    lead = $urandom_range(32'hFFFF_FFFF, diffs * step);
    send_item(1'b1, 1'b1, 1'b1, lead, 1'b1);
    for (int i = 0; i < diffs; i++) begin
      send_item(1'b0, 1'b1, 1'b1, lead - (diffs - i) * step, 1'b1);
      repeat ($urandom_range(3)) send_item(1'b0, 1'b0, 1'($urandom_range(1)), $urandom, 1'b1);
      send_item(1'b0, 1'b1, 1'b1, lead - (diffs - i - 1) * step, 1'b1);
      repeat ($urandom_range(3)) send_item(1'b0, 1'b0, 1'($urandom_range(1)), $urandom, 1'b1);
    end
    send_item(1'b0, 1'b1, 1'b1, lead, 1'b1);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_incr_request(input logic value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= INCR_REQ_ADDR;
    cfg_pwdata  <= {{(CFG_DW-1){1'b0}}, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    settings_used++;
    if (value) incr_settings++;
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full transfer mode straight out of reset, before any first record.
    send_item(1'b0, 1'b0, 1'b1, 32'h0000_0007, 1'b0);
    send_item(1'b0, 1'b1, 1'b1, 32'h0000_0005, 1'b0);
    send_item(1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0);
    send_item(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0);
    send_item(1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
    send_item(1'b0, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
    send_item(1'b1, 1'b1, 1'b1, 32'h0000_0000, 1'b0);
    send_item(1'b0, 1'b1, 1'b1, 32'h0000_0001, 1'b0);
    send_item(1'b1, 1'b1, 1'b1, 32'h0000_0064, 1'b0);
    send_item(1'b0, 1'b1, 1'b0, 32'h0000_0064, 1'b0);
    send_item(1'b1, 1'b1, 1'b1, 32'h0000_0064, 1'b0);
    send_item(1'b0, 1'b1, 1'b1, 32'h0000_0064, 1'b0);
    send_item(1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
    send_item(1'b0, 1'b1, 1'b1, 32'h0000_0064, 1'b0);
    wait_for_results();
    write_incr_request(1'b1);
    send_item(1'b1, 1'b1, 1'b1, 32'h0000_03E8, 1'b0);
    send_item(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0);
    send_item(1'b1, 1'b1, 1'b1, 32'h0000_03E8, 1'b0);
    send_item(1'b0, 1'b1, 1'b1, 32'h0000_000A, 1'b0);
    send_item(1'b0, 1'b0, 1'b1, 32'h0000_0000, 1'b0);
    send_item(1'b0, 1'b1, 1'b1, 32'h0000_0005, 1'b0);
    send_item(1'b1, 1'b1, 1'b1, 32'h0000_03E8, 1'b0);
    send_item(1'b0, 1'b1, 1'b1, 32'h0000_000A, 1'b0);
    send_item(1'b0, 1'b1, 1'b1, 32'h0000_03E8, 1'b0);
    send_item(1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b0);
    send_item(1'b0, 1'b1, 1'b1, 32'h0000_03E8, 1'b0);

    target = records_sent + RANDOM_RECORDS;
    while (records_sent < target) begin
      wait_for_results();
      write_incr_request(settings_used < 3 ? settings_used[0] : 1'($urandom_range(1)));
      quiet_phase <= (settings_used == 5);
      phase_end = records_sent + 90;
      while (records_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          send_ixfr($urandom_range(4));
        end else if (pick < 70) begin
          send_axfr($urandom_range(6));
        end else if (pick < 85) begin
          send_ixfr($urandom_range(1, 3));
          repeat ($urandom_range(1, 2)) send_item(1'b0, 1'($urandom_range(1)),
                                                  1'($urandom_range(1)), $urandom, 1'b0);
        end else begin
          repeat ($urandom_range(1, 4)) send_noise();
        end
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    $display("Sent %0d records under %0d register settings, %0d with incremental requested.",
             records_sent, settings_used, incr_settings);
    $display("Checked %0d results, %0d of them carrying error codes.", checked, error_results);
    if (failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
